/* hdl/oal_pkg.sv */
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types and codes of the ordered array list engine.
// ----------------------------------------------------------------------------
package oal_pkg;

    // request operation codes
    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_POS   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // field widths of the channel words
    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 8;
    localparam int COUNT_W  = 9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_PUT,
        S_DONE
    } oal_state_t;

endpackage

/* hdl/oal_req_if.sv */
// ----------------------------------------------------------------------------
// oal_req_if
// Request channel: valid/ready handshake carrying mode, value and position.
// ----------------------------------------------------------------------------
interface oal_req_if
    import oal_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

/* hdl/oal_rsp_if.sv */
// ----------------------------------------------------------------------------
// oal_rsp_if
// Result channel: valid/ready handshake carrying status, found_index, count.
// ----------------------------------------------------------------------------
interface oal_rsp_if
    import oal_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [FOUND_W-1:0]     found_index;
    logic [COUNT_W-1:0]     count;

    modport source (output valid, output status, output found_index, output count,
                    input ready);
    modport sink   (input valid, input status, input found_index, input count,
                    output ready);
endinterface

/* hdl/oal_ram.sv */
// ----------------------------------------------------------------------------
// oal_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module oal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/ordered_array_list_engine.sv */
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Ordered list kept in a RAM with an element count; find, insert, delete.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request words (mode, value, position), valid/ready handshake.
//   rsp  : one result word (status, found_index, count) per request.
//   The engine works one request at a time; req.ready is high only while
//   no request is in progress. A single RAM read port and write port are
//   walked by a small sequencer, one element per cycle.
//   A find walks the list from index 0 and stops early at the first match.
//   An insert moves the elements from position to the end up one place,
//   then writes the value; an append goes straight to the write. A delete
//   moves the elements above position down one place; deleting the last
//   element needs no move. Rejected requests (full, bad position, unused
//   mode) and a find on an empty list go straight to the result.
//   The result sits in an output register, so a new request is accepted
//   while the previous result waits; a finished result that finds the
//   output register still full waits in the done state until rsp.ready.
//   Reset (rst_n low, asynchronous) empties the list; RAM contents are not
//   cleared and are only read below the count, where they were written.
// ----------------------------------------------------------------------------
module ordered_array_list_engine
    import oal_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    oal_req_if.sink   req,
    oal_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // compare width wide enough for both position and count
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    oal_state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;      // next RAM read address
    logic [CNT_W-1:0]      left_reg, left_next;    // reads still to issue
    logic                  pend_reg, pend_next;    // read data arrives this cycle
    logic [CNT_W-1:0]      paddr_reg, paddr_next;  // address of that read
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [CNT_W-1:0]      res_found_reg, res_found_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [FOUND_W-1:0]    out_found_reg, out_found_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    // RAM port
    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

    // request decode
    logic                  req_fire;
    logic [DATA_WIDTH-1:0] val_in;
    logic [CMP_W-1:0]      pos_c, cnt_c;
    logic                  list_full, ins_bad, del_bad, ins_append, del_last;
    logic                  walk_done, hit, out_free;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign val_in     = DATA_WIDTH'(req.value);   // sign-extends or truncates
    assign pos_c      = CMP_W'(req.position);
    assign cnt_c      = CMP_W'(count_reg);
    assign list_full  = (count_reg == CNT_W'(CAPACITY));
    assign ins_bad    = (pos_c > cnt_c);
    assign ins_append = (pos_c == cnt_c);
    assign del_bad    = (pos_c >= cnt_c);
    assign del_last   = ((pos_c + CMP_W'(1)) == cnt_c);

    assign walk_done  = (left_reg == '0) && !pend_reg;
    assign hit        = pend_reg && (ram_rdata == val_reg);
    assign out_free   = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_index = out_found_reg;
    assign rsp.count       = out_count_reg;

    oal_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.mode)
                        MODE_FIND:
                            state_next = (count_reg == '0) ? S_DONE : S_FIND;
                        MODE_INSERT:
                        begin
                            if (list_full || ins_bad)
                                state_next = S_DONE;
                            else if (ins_append)
                                state_next = S_PUT;
                            else
                                state_next = S_SHIFT_UP;
                        end
                        MODE_DELETE:
                            state_next = (del_bad || del_last) ? S_DONE : S_SHIFT_DOWN;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_FIND:
            begin
                if (hit || walk_done)
                    state_next = S_DONE;
            end
            S_SHIFT_UP:
            begin
                if (walk_done)
                    state_next = S_PUT;
            end
            S_SHIFT_DOWN:
            begin
                if (walk_done)
                    state_next = S_DONE;
            end
            S_PUT:
                state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and RAM control
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        left_next       = left_reg;
        pend_next       = 1'b0;
        paddr_next      = paddr_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg[IDX_W-1:0];

        // issue one read per cycle while the walk has reads left
        if ((state_reg == S_FIND || state_reg == S_SHIFT_UP || state_reg == S_SHIFT_DOWN)
            && left_reg != '0)
        begin
            ram_re     = 1'b1;
            pend_next  = 1'b1;
            paddr_next = idx_reg;
            left_next  = left_reg - CNT_W'(1);
            idx_next   = (state_reg == S_SHIFT_UP) ? idx_reg - CNT_W'(1)
                                                   : idx_reg + CNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    val_next       = val_in;
                    pos_next       = pos_c[CNT_W-1:0];
                    res_found_next = '0;
                    unique case (req.mode)
                        MODE_FIND:
                        begin
                            res_status_next = ST_NOT_FOUND;
                            idx_next        = '0;
                            left_next       = count_reg;
                        end
                        MODE_INSERT:
                        begin
                            if (list_full)
                                res_status_next = ST_FULL;
                            else if (ins_bad)
                                res_status_next = ST_BAD_POS;
                            else
                            begin
                                res_status_next = ST_OK;
                                idx_next        = count_reg - CNT_W'(1);
                                left_next       = count_reg - pos_c[CNT_W-1:0];
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (del_bad)
                                res_status_next = ST_BAD_POS;
                            else
                            begin
                                res_status_next = ST_OK;
                                count_next      = count_reg - CNT_W'(1);
                                idx_next        = pos_c[CNT_W-1:0] + CNT_W'(1);
                                left_next       = count_reg - pos_c[CNT_W-1:0]
                                                  - CNT_W'(1);
                            end
                        end
                        default:
                            res_status_next = ST_BAD_POS;
                    endcase
                end
            end
            S_FIND:
            begin
                if (hit)
                begin
                    res_status_next = ST_OK;
                    res_found_next  = paddr_reg;
                    pend_next       = 1'b0;
                end
            end
            S_SHIFT_UP:
            begin
                // element read last cycle moves one place up
                ram_we    = pend_reg;
                ram_waddr = IDX_W'(paddr_reg + CNT_W'(1));
            end
            S_SHIFT_DOWN:
            begin
                ram_we    = pend_reg;
                ram_waddr = IDX_W'(paddr_reg - CNT_W'(1));
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[IDX_W-1:0];
                ram_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = FOUND_W'(res_found_reg);
                    out_count_next  = COUNT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        left_reg       <= left_next;
        paddr_reg      <= paddr_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |-> (count_reg < CNT_W'(CAPACITY)))
        else $error("insert write into a full list");

    a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(ram_re))
        else $error("read data pending without a read");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CNT_W'(ram_waddr) <= count_reg))
        else $error("RAM write beyond the list end");

endmodule
